// ===== hw/rtl/ogf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the occupancy grid fusion block: sizes, register indexes,
// sequencer states and the divider request and response types.
// No dependencies.
package ogf_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int LOCAL_SIZE = 256;
	localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(CELLS);

	localparam int DIM_W   = 9;
	localparam int COORD_W = 8;
	localparam int PROD_W  = 25;
	localparam int NUM_W   = 36;
	localparam int MAG_W   = 35;
	localparam int DIV_W   = 17;
	localparam int CNT_W   = $clog2(MAG_W + 1);

	localparam logic [2:0] REG_MAP_WIDTH      = 3'd0;
	localparam logic [2:0] REG_MAP_HEIGHT     = 3'd1;
	localparam logic [2:0] REG_MAP_RESOLUTION = 3'd2;
	localparam logic [2:0] REG_MAP_ORIGIN_X   = 3'd3;
	localparam logic [2:0] REG_MAP_ORIGIN_Y   = 3'd4;

	localparam logic CMD_FUSE = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [7:0] CELL_UNKNOWN = 8'hFF;
	localparam logic signed [8:0] OCC_MID = 9'sd50;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_NUM,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_IDX,
		ST_RCHK,
		ST_RD,
		ST_DECIDE,
		ST_FIN
	} ogf_state_t;

	typedef struct packed {
		logic             start;
		logic [MAG_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [MAG_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== hw/rtl/ogf_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the occupancy grid fusion block: valid, ready and one item.
// No dependencies.
interface ogf_in_if;
	logic               valid;
	logic               ready;
	logic               cmd;
	logic [7:0]         local_col;
	logic [7:0]         local_row;
	logic signed [7:0]  occupancy;
	logic signed [31:0] local_origin_x;
	logic signed [31:0] local_origin_y;
	logic [15:0]        local_cell_size;
	logic [15:0]        read_index;

	modport source (
		output valid, cmd, local_col, local_row, occupancy,
		output local_origin_x, local_origin_y, local_cell_size, read_index,
		input  ready
	);
	modport sink (
		input  valid, cmd, local_col, local_row, occupancy,
		input  local_origin_x, local_origin_y, local_cell_size, read_index,
		output ready
	);
endinterface

// ===== hw/rtl/ogf_out_if.sv =====
`timescale 1ns / 1ps
// Result channel of the occupancy grid fusion block: valid, ready and one item.
// No dependencies.
interface ogf_out_if;
	logic              valid;
	logic              ready;
	logic signed [7:0] cell_value;
	logic [15:0]       cell_index;
	logic              in_bounds;
	logic              updated;

	modport source (
		output valid, cell_value, cell_index, in_bounds, updated,
		input  ready
	);
	modport sink (
		input  valid, cell_value, cell_index, in_bounds, updated,
		output ready
	);
endinterface

// ===== hw/rtl/ogf_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port RAM with one write or read per cycle and registered read data.
// No dependencies.
module ogf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== hw/rtl/ogf_div.sv =====
`timescale 1ns / 1ps
// Restoring divider for unsigned magnitudes, one quotient bit per cycle.
// Depends on ogf_pkg.
module ogf_div import ogf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] count_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] divisor_q;
	logic [MAG_W-1:0] quo_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W+1:0] diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[MAG_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor_q};
	assign ge      = ~diff[DIV_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= CNT_W'(MAG_W);
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q     <= req.dividend;
			rem_q     <= '0;
			divisor_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[MAG_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== hw/rtl/occupancy_grid_fusion.sv =====
`timescale 1ns / 1ps
// Occupancy grid fusion: merges local cells into a 256 x 256 global grid.
// A fuse item makes two passes of the 35-step shared divider, one per axis, then reads
// and updates the cell unless it falls off the grid; a read item needs no divider pass.
// One item is in work at a time; the next is taken the cycle after the result is loaded.
// After reset the grid is swept to unknown, one cell a cycle, before the first item is
// taken. Depends on ogf_pkg, ogf_in_if, ogf_out_if, ogf_ram and ogf_div.
module occupancy_grid_fusion import ogf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ogf_in_if.sink      req,
	ogf_out_if.source   rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	ogf_state_t state_q, state_d;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [15:0]        res_q;
	logic signed [31:0] gox_q;
	logic signed [31:0] goy_q;

	logic [ADDR_W-1:0] clr_addr_q;
	logic              axis_q;
	logic              out_valid_q;

	logic               cmd_q;
	logic [7:0]         col_q;
	logic [7:0]         row_q;
	logic [7:0]         occ_q;
	logic signed [31:0] lox_q;
	logic signed [31:0] loy_q;
	logic [15:0]        lres_q;
	logic [15:0]        ridx_q;

	logic [PROD_W-1:0]  prod_q;
	logic               neg_q;
	logic [MAG_W-1:0]   mag_q;
	logic [COORD_W-1:0] mx_q;
	logic [COORD_W-1:0] my_q;
	logic               xin_q;
	logic [ADDR_W-1:0]  gi_q;

	logic [7:0]  res_value_q;
	logic [15:0] res_index_q;
	logic        res_inb_q;
	logic        res_upd_q;

	logic [7:0]  out_value_q;
	logic [15:0] out_index_q;
	logic        out_inb_q;
	logic        out_upd_q;

	logic [DIM_W-1:0]      eff_w;
	logic [DIM_W-1:0]      eff_h;
	logic [15:0]           res_eff;
	logic                  accept;
	logic                  local_oob;
	logic signed [31:0]    lo_sel;
	logic signed [31:0]    go_sel;
	logic signed [NUM_W-1:0] num_c;
	logic [DIM_W-1:0]      dim_sel;
	logic                  coord_in;
	logic                  rd_in;
	logic                  take;
	logic                  out_free;

	logic             ram_we;
	logic             ram_re;
	logic [ADDR_W-1:0] ram_addr;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	function automatic logic [8:0] dist50(logic [7:0] v);
		logic signed [8:0] d;
		d = $signed({v[7], v}) - OCC_MID;
		return d[8] ? 9'(-d) : 9'(d);
	endfunction

	assign eff_w   = (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
	assign eff_h   = (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
	assign res_eff = (res_q == 16'd0) ? 16'd1 : res_q;

	assign accept    = req.valid && req.ready;
	assign local_oob = (int'(req.local_col) >= LOCAL_SIZE) ||
	                   (int'(req.local_row) >= LOCAL_SIZE);

	assign lo_sel  = axis_q ? loy_q : lox_q;
	assign go_sel  = axis_q ? goy_q : gox_q;
	assign dim_sel = axis_q ? eff_h : eff_w;
	assign num_c   = $signed({{3{lo_sel[31]}}, lo_sel, 1'b0})
	               + $signed({{(NUM_W-PROD_W){1'b0}}, prod_q})
	               - $signed({{3{go_sel[31]}}, go_sel, 1'b0});

	assign coord_in = (div_rsp.quotient < MAG_W'(dim_sel)) &&
	                  (!neg_q || (div_rsp.quotient == '0));
	assign rd_in    = 18'(ridx_q) < (18'(eff_w) * 18'(eff_h));
	assign take     = (ram_rdata == CELL_UNKNOWN) || (dist50(occ_q) > dist50(ram_rdata));
	assign out_free = !out_valid_q || rsp.ready;

	assign div_req.start    = (state_q == ST_DIV_GO);
	assign div_req.dividend = mag_q;
	assign div_req.divisor  = {res_eff, 1'b0};

	ogf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign ram_we    = (state_q == ST_CLEAR) ||
	                   ((state_q == ST_DECIDE) && (cmd_q == CMD_FUSE) && take);
	assign ram_re    = (state_q == ST_RD);
	assign ram_addr  = (state_q == ST_CLEAR) ? clr_addr_q : gi_q;
	assign ram_wdata = (state_q == ST_CLEAR) ? CELL_UNKNOWN : occ_q;

	ogf_ram #(
		.WIDTH (8),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == ADDR_W'(CELLS - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req.valid) begin
					if (req.cmd == CMD_READ) state_d = ST_RCHK;
					else if (local_oob)      state_d = ST_FIN;
					else                     state_d = ST_MUL;
				end
			end
			ST_MUL:    state_d = ST_NUM;
			ST_NUM:    state_d = ST_DIV_GO;
			ST_DIV_GO: state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					if (!axis_q)                  state_d = ST_MUL;
					else if (xin_q && coord_in)   state_d = ST_IDX;
					else                          state_d = ST_FIN;
				end
			end
			ST_IDX:    state_d = ST_RD;
			ST_RCHK:   state_d = rd_in ? ST_RD : ST_FIN;
			ST_RD:     state_d = ST_DECIDE;
			ST_DECIDE: state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
			width_q     <= DIM_W'(256);
			height_q    <= DIM_W'(256);
			res_q       <= 16'd102;
			gox_q       <= '0;
			goy_q       <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (accept) begin
				axis_q <= 1'b0;
			end else if ((state_q == ST_DIV_WAIT) && div_rsp.done) begin
				axis_q <= 1'b1;
			end
			if ((state_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAP_WIDTH:      width_q  <= cfg_data[DIM_W-1:0];
					REG_MAP_HEIGHT:     height_q <= cfg_data[DIM_W-1:0];
					REG_MAP_RESOLUTION: res_q    <= cfg_data[15:0];
					REG_MAP_ORIGIN_X:   gox_q    <= $signed(cfg_data);
					REG_MAP_ORIGIN_Y:   goy_q    <= $signed(cfg_data);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q       <= req.cmd;
			col_q       <= req.local_col;
			row_q       <= req.local_row;
			occ_q       <= req.occupancy;
			lox_q       <= req.local_origin_x;
			loy_q       <= req.local_origin_y;
			lres_q      <= req.local_cell_size;
			ridx_q      <= req.read_index;
			res_value_q <= CELL_UNKNOWN;
			res_index_q <= '0;
			res_inb_q   <= 1'b0;
			res_upd_q   <= 1'b0;
		end
		unique case (state_q)
			ST_MUL: begin
				prod_q <= PROD_W'({axis_q ? row_q : col_q, 1'b1}) * PROD_W'(lres_q);
			end
			ST_NUM: begin
				neg_q <= num_c[NUM_W-1];
				mag_q <= MAG_W'(num_c[NUM_W-1] ? -num_c : num_c);
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					if (!axis_q) begin
						mx_q  <= div_rsp.quotient[COORD_W-1:0];
						xin_q <= coord_in;
					end else begin
						my_q <= div_rsp.quotient[COORD_W-1:0];
					end
				end
			end
			ST_IDX: begin
				gi_q <= ADDR_W'((17'(my_q) * 17'(eff_w)) + 17'(mx_q));
			end
			ST_RCHK: begin
				gi_q        <= ADDR_W'(ridx_q);
				res_index_q <= ridx_q;
			end
			ST_DECIDE: begin
				res_inb_q <= 1'b1;
				if (cmd_q == CMD_READ) begin
					res_value_q <= ram_rdata;
				end else begin
					res_value_q <= take ? occ_q : ram_rdata;
					res_index_q <= 16'(gi_q);
					res_upd_q   <= take;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_value_q <= res_value_q;
					out_index_q <= res_index_q;
					out_inb_q   <= res_inb_q;
					out_upd_q   <= res_upd_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.cell_value = $signed(out_value_q);
	assign rsp.cell_index = out_index_q;
	assign rsp.in_bounds  = out_inb_q;
	assign rsp.updated    = out_upd_q;

endmodule
